/* rtl/mfss_pkg.sv */
// Shared types, constants and descriptor decode for the frame slot scheduler.
package mfss_pkg;

	localparam int SLOTS        = 20;
	localparam int SLOT_W       = $clog2(SLOTS);
	localparam int MOD5_W       = 3;
	localparam int STOP_STEP_W  = 4;
	localparam int RUN_STEP_W   = 3;
	localparam int MASK_W       = 5;
	localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(22);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	// frame kinds
	localparam logic [3:0] KIND_MIT       = 4'd0;
	localparam logic [3:0] KIND_JOINT_GRP = 4'd1;
	localparam logic [3:0] KIND_WHEEL_GRP = 4'd2;
	localparam logic [3:0] KIND_STIR      = 4'd3;
	localparam logic [3:0] KIND_POWER     = 4'd4;
	localparam logic [3:0] KIND_LOCK      = 4'd5;
	localparam logic [3:0] KIND_CLEAR     = 4'd6;
	localparam logic [3:0] KIND_START     = 4'd7;
	localparam logic [3:0] KIND_LINK_IN   = 4'd8;
	localparam logic [3:0] KIND_LINK_BODY = 4'd9;
	localparam logic [3:0] KIND_LINK_KEYS = 4'd10;

	// motor indexes
	localparam logic [2:0] MOTOR_YAW    = 3'd4;
	localparam logic [2:0] MOTOR_STIR   = 3'd5;
	localparam logic [2:0] MOTOR_LTRACK = 3'd6;
	localparam logic [2:0] MOTOR_RTRACK = 3'd7;
	localparam logic [2:0] MOTOR_NONE   = 3'd0;

	// mask bits
	localparam int MB_YAW    = 0;
	localparam int MB_JOINTS = 1;
	localparam int MB_WHEELS = 2;
	localparam int MB_STIR   = 3;
	localparam int MB_TRACKS = 4;

	// descriptor positions within a tick, in emission order
	localparam int NUM_POS = 14;
	localparam int POS_W   = $clog2(NUM_POS);
	localparam logic [POS_W-1:0] POS_YAW       = POS_W'(0);
	localparam logic [POS_W-1:0] POS_JOINT0    = POS_W'(1);
	localparam logic [POS_W-1:0] POS_JOINT1    = POS_W'(2);
	localparam logic [POS_W-1:0] POS_JOINT2    = POS_W'(3);
	localparam logic [POS_W-1:0] POS_JOINT3    = POS_W'(4);
	localparam logic [POS_W-1:0] POS_WHEEL     = POS_W'(5);
	localparam logic [POS_W-1:0] POS_STIR      = POS_W'(6);
	localparam logic [POS_W-1:0] POS_LTRACK    = POS_W'(7);
	localparam logic [POS_W-1:0] POS_RTRACK    = POS_W'(8);
	localparam logic [POS_W-1:0] POS_POWER     = POS_W'(9);
	localparam logic [POS_W-1:0] POS_MAINT     = POS_W'(10);
	localparam logic [POS_W-1:0] POS_LINK_IN   = POS_W'(11);
	localparam logic [POS_W-1:0] POS_LINK_BODY = POS_W'(12);
	localparam logic [POS_W-1:0] POS_LINK_KEYS = POS_W'(13);

	typedef struct packed {
		logic              stop;
		logic [MASK_W-1:0] mask;
		logic [NUM_POS-1:0] en;
		logic              mbus;
		logic [3:0]        mkind;
		logic [2:0]        mmotor;
	} plan_t;

	typedef struct packed {
		logic       bus;
		logic [3:0] kind;
		logic [2:0] motor;
		logic       zero;
	} desc_t;

	function automatic desc_t pos_desc(input logic [POS_W-1:0] pos, input plan_t p);
		desc_t d;
		d = '{bus: 1'b0, kind: KIND_LINK_IN, motor: MOTOR_NONE, zero: 1'b0};
		case (pos)
			POS_YAW: begin
				d = '{1'b0, KIND_MIT, MOTOR_YAW, p.stop | p.mask[MB_YAW]};
			end
			POS_JOINT0: begin
				if (p.stop)
					d = '{1'b0, KIND_JOINT_GRP, MOTOR_NONE, 1'b1};
				else
					d = '{1'b0, KIND_MIT, 3'd0, p.mask[MB_JOINTS]};
			end
			POS_JOINT1: d = '{1'b0, KIND_MIT, 3'd1, p.mask[MB_JOINTS]};
			POS_JOINT2: d = '{1'b0, KIND_MIT, 3'd2, p.mask[MB_JOINTS]};
			POS_JOINT3: d = '{1'b0, KIND_MIT, 3'd3, p.mask[MB_JOINTS]};
			POS_WHEEL: begin
				d = '{1'b1, KIND_WHEEL_GRP, MOTOR_NONE, p.stop | p.mask[MB_WHEELS]};
			end
			POS_STIR:  d = '{1'b0, KIND_STIR, MOTOR_STIR, p.stop | p.mask[MB_STIR]};
			POS_LTRACK: d = '{1'b1, KIND_MIT, MOTOR_LTRACK, p.stop | p.mask[MB_TRACKS]};
			POS_RTRACK: d = '{1'b1, KIND_MIT, MOTOR_RTRACK, p.stop | p.mask[MB_TRACKS]};
			POS_POWER: d = '{1'b1, KIND_POWER, MOTOR_NONE, 1'b0};
			POS_MAINT: d = '{p.mbus, p.mkind, p.mmotor, 1'b0};
			POS_LINK_IN: d = '{1'b0, KIND_LINK_IN, MOTOR_NONE, 1'b0};
			POS_LINK_BODY: d = '{1'b0, KIND_LINK_BODY, MOTOR_NONE, 1'b0};
			POS_LINK_KEYS: d = '{1'b0, KIND_LINK_KEYS, MOTOR_NONE, 1'b0};
			default: d = '{1'b0, KIND_LINK_IN, MOTOR_NONE, 1'b0};
		endcase
		return d;
	endfunction

endpackage

/* rtl/multirate_frame_slot_scheduler.sv */
// Top level: frame slot scheduler, front end, plan queue and descriptor back end.
// A plan is registered in the queue, then in the back end, then as a descriptor.
// Throughput: one descriptor per cycle unless out_stall holds it; a tick of 4 to 10
//   descriptors holds the back end, ticks follow with no gap while work is queued.
// Input stalls only when the 2-entry plan queue is full.
// Reset: counters cleared, mask set to 22, queue and output emptied.
module multirate_frame_slot_scheduler import mfss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [MASK_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              stop_mode,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              bus_select,
	output logic [3:0]        frame_kind,
	output logic [2:0]        motor_index,
	output logic              zero_payload,
	output logic              last_frame
);

	plan_t push_plan;
	plan_t pop_plan;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;
	desc_t desc;

	mfss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.stop_mode (stop_mode),
		.q_full    (full),
		.q_push    (push),
		.q_plan    (push_plan)
	);

	mfss_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_plan (push_plan),
		.pop     (pop),
		.rd_plan (pop_plan),
		.full    (full),
		.empty   (empty)
	);

	mfss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (empty),
		.q_plan    (pop_plan),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_desc  (desc),
		.out_last  (last_frame)
	);

	assign bus_select   = desc.bus;
	assign frame_kind   = desc.kind;
	assign motor_index  = desc.motor;
	assign zero_payload = desc.zero;

endmodule

/* rtl/mfss_front.sv */
// Front end: config register, slot and maintenance counters, per-tick plan build.
module mfss_front import mfss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [MASK_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              stop_mode,
	input  logic              q_full,
	output logic              q_push,
	output plan_t             q_plan
);

	logic [MASK_W-1:0]      mask_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [MOD5_W-1:0]      mod5_q;
	logic [STOP_STEP_W-1:0] stop_step_q;
	logic [RUN_STEP_W-1:0]  run_step_q;

	assign in_stall = q_full;
	assign q_push   = in_valid & ~q_full;

	always_comb begin
		q_plan.stop = stop_mode;
		q_plan.mask = mask_q;
		q_plan.en   = '0;
		q_plan.en[POS_YAW]       = 1'b1;
		q_plan.en[POS_JOINT0]    = ~slot_q[0];
		q_plan.en[POS_JOINT1]    = ~slot_q[0] & ~stop_mode;
		q_plan.en[POS_JOINT2]    = ~slot_q[0] & ~stop_mode;
		q_plan.en[POS_JOINT3]    = ~slot_q[0] & ~stop_mode;
		q_plan.en[POS_WHEEL]     = ~slot_q[0];
		q_plan.en[POS_STIR]      = (mod5_q == MOD5_W'(0));
		q_plan.en[POS_LTRACK]    = (slot_q[1:0] == 2'd1);
		q_plan.en[POS_RTRACK]    = (slot_q[1:0] == 2'd1);
		q_plan.en[POS_POWER]     = (mod5_q == MOD5_W'(3));
		q_plan.en[POS_MAINT]     = 1'b1;
		q_plan.en[POS_LINK_IN]   = 1'b1;
		q_plan.en[POS_LINK_BODY] = 1'b1;
		q_plan.en[POS_LINK_KEYS] = (mod5_q == MOD5_W'(4));
		if (stop_mode) begin
			if (stop_step_q < STOP_STEP_W'(6)) begin
				q_plan.mbus   = 1'b0;
				q_plan.mkind  = KIND_LOCK;
				q_plan.mmotor = stop_step_q[2:0];
			end else if (stop_step_q < STOP_STEP_W'(12)) begin
				q_plan.mbus   = 1'b0;
				q_plan.mkind  = KIND_CLEAR;
				q_plan.mmotor = 3'(stop_step_q - STOP_STEP_W'(6));
			end else if (stop_step_q < STOP_STEP_W'(14)) begin
				q_plan.mbus   = 1'b1;
				q_plan.mkind  = KIND_LOCK;
				q_plan.mmotor = 3'(stop_step_q - STOP_STEP_W'(6));
			end else begin
				q_plan.mbus   = 1'b1;
				q_plan.mkind  = KIND_CLEAR;
				q_plan.mmotor = 3'(stop_step_q - STOP_STEP_W'(8));
			end
		end else begin
			q_plan.mbus   = (run_step_q >= RUN_STEP_W'(6));
			q_plan.mkind  = KIND_START;
			q_plan.mmotor = run_step_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= MASK_RESET;
			slot_q      <= '0;
			mod5_q      <= '0;
			stop_step_q <= '0;
			run_step_q  <= '0;
		end else begin
			if (cfg_wen)
				mask_q <= cfg_wdata;
			if (q_push) begin
				slot_q <= (slot_q == SLOT_W'(SLOTS - 1)) ? '0 : slot_q + SLOT_W'(1);
				mod5_q <= (mod5_q == MOD5_W'(4)) ? '0 : mod5_q + MOD5_W'(1);
				if (stop_mode)
					stop_step_q <= stop_step_q + STOP_STEP_W'(1);
				else
					run_step_q <= run_step_q + RUN_STEP_W'(1);
			end
		end
	end

endmodule

/* rtl/mfss_queue.sv */
// Short plan queue between front and back ends.
module mfss_queue import mfss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  plan_t wr_plan,
	input  logic  pop,
	output plan_t rd_plan,
	output logic  full,
	output logic  empty
);

	plan_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_plan = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_plan;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/mfss_back.sv */
// Back end: walks the enabled positions of a plan, one registered descriptor per cycle while the output is not stalled.
module mfss_back import mfss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_empty,
	input  plan_t q_plan,
	output logic  q_pop,
	output logic  out_valid,
	input  logic  out_stall,
	output desc_t out_desc,
	output logic  out_last
);

	plan_t              plan_q;
	logic [NUM_POS-1:0] rem_q;
	logic               out_valid_q;
	desc_t              desc_q;
	logic               last_q;

	logic               adv;
	logic               emit;
	logic [NUM_POS-1:0] rem_clr;
	logic [NUM_POS-1:0] rem_after;
	logic [POS_W-1:0]   pos;

	assign adv       = ~out_valid_q | ~out_stall;
	assign emit      = adv & (|rem_q);
	assign rem_clr   = rem_q & (rem_q - NUM_POS'(1));
	assign rem_after = emit ? rem_clr : rem_q;
	assign q_pop     = ~q_empty & (rem_after == '0);

	always_comb begin
		pos = '0;
		for (int i = NUM_POS - 1; i >= 0; i--) begin
			if (rem_q[i])
				pos = POS_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			plan_q <= q_plan;
		if (emit) begin
			desc_q <= pos_desc(pos, plan_q);
			last_q <= (rem_clr == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rem_q <= q_pop ? q_plan.en : rem_after;
			if (adv)
				out_valid_q <= |rem_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_desc  = desc_q;
	assign out_last  = last_q;

endmodule

/* test/frame_schedule_checker.sv */
// Checker for the frame slot scheduler: predicts each tick's descriptors and compares transfers.
`timescale 1ns / 1ps
module frame_schedule_checker import mfss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [MASK_W-1:0] cfg_wdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              stop_mode,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              bus_select,
	input  logic [3:0]        frame_kind,
	input  logic [2:0]        motor_index,
	input  logic              zero_payload,
	input  logic              last_frame,
	output int                errors,
	output int                outstanding,
	output int                ticks_seen,
	output int                frames_seen
);

	typedef struct packed {
		logic       bus;
		logic [3:0] kind;
		logic [2:0] motor;
		logic       zero;
		logic       last;
	} frame_t;

	frame_t frames_due[$];

	logic [MASK_W-1:0]      mask_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [STOP_STEP_W-1:0] stop_step_q;
	logic [RUN_STEP_W-1:0]  run_step_q;

	function automatic void add_frame(input logic bus, input logic [3:0] kind,
			input logic [2:0] motor, input logic zero);
		frame_t f;
		f = '{bus: bus, kind: kind, motor: motor, zero: zero, last: 1'b0};
		frames_due.push_back(f);
	endfunction

	// Appends the descriptors of one tick and advances the schedule state.
	function automatic void schedule_tick(input logic stop);
		int slot;
		int s;
		slot = int'(slot_q);
		if (stop) begin
			add_frame(1'b0, KIND_MIT, MOTOR_YAW, 1'b1);
			if (slot % 2 == 0) begin
				add_frame(1'b0, KIND_JOINT_GRP, MOTOR_NONE, 1'b1);
				add_frame(1'b1, KIND_WHEEL_GRP, MOTOR_NONE, 1'b1);
			end
			if (slot % 5 == 0)
				add_frame(1'b0, KIND_STIR, MOTOR_STIR, 1'b1);
			if (slot % 4 == 1) begin
				add_frame(1'b1, KIND_MIT, MOTOR_LTRACK, 1'b1);
				add_frame(1'b1, KIND_MIT, MOTOR_RTRACK, 1'b1);
			end
			if (slot % 5 == 3)
				add_frame(1'b1, KIND_POWER, MOTOR_NONE, 1'b0);
			s = int'(stop_step_q);
			if (s < 6)
				add_frame(1'b0, KIND_LOCK, 3'(s), 1'b0);
			else if (s < 12)
				add_frame(1'b0, KIND_CLEAR, 3'(s - 6), 1'b0);
			else if (s < 14)
				add_frame(1'b1, KIND_LOCK, 3'(6 + s - 12), 1'b0);
			else
				add_frame(1'b1, KIND_CLEAR, 3'(6 + s - 14), 1'b0);
			stop_step_q = stop_step_q + STOP_STEP_W'(1);
		end else begin
			add_frame(1'b0, KIND_MIT, MOTOR_YAW, mask_q[MB_YAW]);
			if (slot % 2 == 0) begin
				for (int j = 0; j < 4; j++)
					add_frame(1'b0, KIND_MIT, 3'(j), mask_q[MB_JOINTS]);
				add_frame(1'b1, KIND_WHEEL_GRP, MOTOR_NONE, mask_q[MB_WHEELS]);
			end
			if (slot % 5 == 0)
				add_frame(1'b0, KIND_STIR, MOTOR_STIR, mask_q[MB_STIR]);
			if (slot % 4 == 1) begin
				add_frame(1'b1, KIND_MIT, MOTOR_LTRACK, mask_q[MB_TRACKS]);
				add_frame(1'b1, KIND_MIT, MOTOR_RTRACK, mask_q[MB_TRACKS]);
			end
			if (slot % 5 == 3)
				add_frame(1'b1, KIND_POWER, MOTOR_NONE, 1'b0);
			s = int'(run_step_q);
			if (s < 6)
				add_frame(1'b0, KIND_START, 3'(s), 1'b0);
			else
				add_frame(1'b1, KIND_START, 3'(6 + s - 6), 1'b0);
			run_step_q = run_step_q + RUN_STEP_W'(1);
		end
		slot = (slot + 1) % SLOTS;
		slot_q = SLOT_W'(slot);
		add_frame(1'b0, KIND_LINK_IN, MOTOR_NONE, 1'b0);
		add_frame(1'b0, KIND_LINK_BODY, MOTOR_NONE, 1'b0);
		if (slot % 5 == 0)
			add_frame(1'b0, KIND_LINK_KEYS, MOTOR_NONE, 1'b0);
		frames_due[$].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_t got;
		frame_t want;
		if (!arst_n) begin
			frames_due.delete();
			mask_q      = MASK_RESET;
			slot_q      = '0;
			stop_step_q = '0;
			run_step_q  = '0;
			errors      <= 0;
			outstanding <= 0;
			ticks_seen  <= 0;
			frames_seen <= 0;
		end else begin
			if (cfg_wen)
				mask_q = cfg_wdata;
			if (out_valid && !out_stall) begin
				frames_seen <= frames_seen + 1;
				got = '{bus: bus_select, kind: frame_kind, motor: motor_index,
					zero: zero_payload, last: last_frame};
				if (frames_due.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected descriptor bus %0d kind %0d motor %0d zero %0d last %0d",
							$time, got.bus, got.kind, got.motor, got.zero, got.last);
					errors <= errors + 1;
				end else begin
					want = frames_due.pop_front();
					if (got != want) begin
						if (errors < 10)
							$display({"%0t: descriptor mismatch, expected bus %0d kind %0d motor %0d ",
								"zero %0d last %0d, got bus %0d kind %0d motor %0d zero %0d last %0d"},
								$time, want.bus, want.kind, want.motor, want.zero, want.last,
								got.bus, got.kind, got.motor, got.zero, got.last);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				ticks_seen <= ticks_seen + 1;
				schedule_tick(stop_mode);
			end
			outstanding <= frames_due.size();
		end
	end

endmodule

/* test/tb_multirate_frame_slot_scheduler.sv */
// Testbench top for the frame slot scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_multirate_frame_slot_scheduler;
	import mfss_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_wen;
	logic [MASK_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_stall;
	logic              stop_mode;
	logic              out_valid;
	logic              out_stall;
	logic              bus_select;
	logic [3:0]        frame_kind;
	logic [2:0]        motor_index;
	logic              zero_payload;
	logic              last_frame;

	int chk_errors;
	int pending;
	int ticks_seen;
	int frames_seen;
	int stop_ticks;
	int mask_writes;
	bit quiet;

	multirate_frame_slot_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stop_mode(stop_mode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bus_select(bus_select),
		.frame_kind(frame_kind),
		.motor_index(motor_index),
		.zero_payload(zero_payload),
		.last_frame(last_frame)
	);

	frame_schedule_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stop_mode(stop_mode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bus_select(bus_select),
		.frame_kind(frame_kind),
		.motor_index(motor_index),
		.zero_payload(zero_payload),
		.last_frame(last_frame),
		.errors(chk_errors),
		.outstanding(pending),
		.ticks_seen(ticks_seen),
		.frames_seen(frames_seen)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#10ms;
		$display("timeout: %0d descriptors still expected", pending);
		$display("FAIL");
		$finish;
	end

	// output side: random stall before each descriptor transfer
	initial begin
		int gap;
		out_stall = 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 10);
			repeat (gap) begin
				out_stall <= 1'b1;
				@(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic send_tick(input logic stop);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		stop_mode <= stop;
		do @(posedge clk); while (in_stall);
		if (stop)
			stop_ticks++;
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending != 0 && waited < 5000);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_mask(input logic [MASK_W-1:0] value);
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		mask_writes++;
	endtask

	initial begin
		logic [MASK_W-1:0] masks[6];
		logic              mode;
		arst_n    = 1'b0;
		cfg_wen   = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		stop_mode = 1'b0;
		quiet     = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset mask, both modes on both slot parities, full slot cycle
		for (int i = 0; i < 22; i++)
			send_tick(i[1]);

		masks = '{5'd0, 5'd31, 5'b10101, 5'b01010, MASK_W'($urandom), MASK_W'($urandom)};
		for (int p = 0; p < 6; p++) begin
			write_mask(masks[p]);
			quiet = (p == 3);
			mode  = 1'($urandom_range(0, 1));
			repeat (80) begin
				if ($urandom_range(0, 7) == 0)
					mode = ~mode;
				send_tick(mode);
			end
		end
		quiet = 1'b0;
		drain();

		if (pending != 0)
			$display("%0d expected descriptors never arrived", pending);
		$display("Run covered %0d ticks (%0d stopped) and %0d descriptors over %0d mask writes",
			ticks_seen, stop_ticks, frames_seen, mask_writes);
		$display("Descriptor mismatches: %0d", chk_errors);
		if (chk_errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
